[rtl/mspwm_pkg.sv]
// Shared types and constants for the multichannel soft PWM block.
// Used by mspwm_front, mspwm_engine and multichannel_soft_pwm; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mspwm_pkg;

    localparam int DATA_W = 8;

    // Most pin writes that one tick may produce.
    localparam int MAX_RESULTS = 8;
    localparam int NRES_W      = 4;

    // Command codes of an input word.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // Configuration register indexes.
    localparam int               CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_STEP = 2'd1;

    localparam logic [DATA_W-1:0] MASK_RESET   = 8'hff;
    localparam logic [DATA_W-1:0] STEP_RESET   = 8'd1;
    localparam logic [DATA_W-1:0] PERIOD_RESET = 8'hff;

    // Input queue: two entries.
    localparam int              QCNT_W    = 2;
    localparam logic [QCNT_W-1:0] QCNT_FULL = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [DATA_W-1:0] pin;
        logic [DATA_W-1:0] duty;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] out_pin;
        logic              level;
        logic              last;
    } t_out_item;

    // Head of the input queue as seen by the engine.
    typedef struct packed {
        logic     valid;
        logic     is_set;
        t_in_item item;
    } t_head;

    typedef struct packed {
        logic [DATA_W-1:0] duty_mask;
        logic [DATA_W-1:0] count_step;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_SCAN,
        ST_TICK_HIGH,
        ST_TICK_LOW,
        ST_FLUSH
    } t_eng_state;

endpackage

`default_nettype wire

[rtl/mspwm_front.sv]
// Front end: accepts input words into a two-entry queue and classifies them.
// Depends on mspwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mspwm_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  mspwm_pkg::t_in_item     i_in_data,
    input  wire logic               i_pop,
    output mspwm_pkg::t_head        o_head
);
    import mspwm_pkg::*;

    t_in_item          r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_in_stall = (r_count == QCNT_FULL);
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_count != '0);

    always_comb begin
        o_head.valid  = (r_count != '0);
        o_head.item   = r_mem[r_rd_ptr];
        o_head.is_set = (r_mem[r_rd_ptr].cmd == CMD_SET);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_in_data;
        end
    end

endmodule

`default_nettype wire

[rtl/mspwm_engine.sv]
// Back end: channel table, period counter and the per-channel scan sequencer,
// with the output register. Depends on mspwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mspwm_engine #(
    parameter int CHANNELS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  mspwm_pkg::t_head                  i_head,
    output logic                              o_pop,
    input  mspwm_pkg::t_cfg                   i_cfg,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output mspwm_pkg::t_out_item              o_out_data,
    output logic                              o_busy,
    output logic [$clog2(CHANNELS+1)-1:0]     o_used
);
    import mspwm_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int UW = $clog2(CHANNELS + 1);

    t_eng_state        r_state;
    t_eng_state        n_state;
    logic [CW-1:0]     r_idx;
    logic [UW-1:0]     r_used;
    logic [DATA_W-1:0] r_period;
    logic [DATA_W-1:0] r_chan_pin     [CHANNELS];
    logic [DATA_W-1:0] r_chan_duty    [CHANNELS];
    logic [DATA_W-1:0] r_chan_latched [CHANNELS];
    logic [DATA_W-1:0] r_cmd_pin;
    logic [DATA_W-1:0] r_cmd_duty;
    logic              r_pend_valid;
    logic [DATA_W-1:0] r_pend_pin;
    logic              r_pend_level;
    logic [NRES_W-1:0] r_nres;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [UW-1:0]     w_idx_ext;
    logic              w_at_used;
    logic              w_last_ch;
    logic              w_full;
    logic [DATA_W-1:0] w_cur_pin;
    logic [DATA_W-1:0] w_cur_latched;
    logic [DATA_W-1:0] w_masked;
    logic              w_match;
    logic              w_hit_high;
    logic              w_hit_low;
    logic              w_out_free;

    logic              w_ld_cmd;
    logic              w_tick_start;
    logic              w_idx_clr;
    logic              w_idx_inc;
    logic              w_bind;
    logic              w_update;
    logic              w_latch;
    logic              w_keep;
    logic              w_level;
    logic              w_push_mid;
    logic              w_push_last;
    logic              w_adv_period;

    assign w_idx_ext     = UW'(r_idx);
    assign w_at_used     = (w_idx_ext == r_used);
    assign w_last_ch     = ((w_idx_ext + UW'(1)) == r_used);
    assign w_full        = (r_used == UW'(CHANNELS));
    assign w_cur_pin     = r_chan_pin[r_idx];
    assign w_cur_latched = r_chan_latched[r_idx];
    assign w_masked      = r_chan_duty[r_idx] & i_cfg.duty_mask;
    assign w_match       = !w_at_used && (w_cur_pin == r_cmd_pin);
    assign w_hit_high    = (w_masked != '0);
    assign w_hit_low     = (w_cur_latched == r_period) && (w_cur_latched != i_cfg.duty_mask);
    assign w_out_free    = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.is_set) begin
                        n_state = ST_SET_SCAN;
                    end else if (r_used == '0) begin
                        n_state = ST_FLUSH;
                    end else if (r_period == '0) begin
                        n_state = ST_TICK_HIGH;
                    end else begin
                        n_state = ST_TICK_LOW;
                    end
                end
            end
            ST_SET_SCAN: begin
                if (w_at_used || w_match || (w_last_ch && w_full)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TICK_HIGH: begin
                if (w_out_free && w_last_ch) begin
                    n_state = ST_TICK_LOW;
                end
            end
            ST_TICK_LOW: begin
                if (w_out_free && w_last_ch) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs per state.
    always_comb begin
        o_pop        = 1'b0;
        w_ld_cmd     = 1'b0;
        w_tick_start = 1'b0;
        w_idx_clr    = 1'b0;
        w_idx_inc    = 1'b0;
        w_bind       = 1'b0;
        w_update     = 1'b0;
        w_latch      = 1'b0;
        w_keep       = 1'b0;
        w_level      = 1'b0;
        w_push_mid   = 1'b0;
        w_push_last  = 1'b0;
        w_adv_period = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop        = 1'b1;
                    w_ld_cmd     = 1'b1;
                    w_idx_clr    = 1'b1;
                    w_tick_start = !i_head.is_set;
                end
            end
            ST_SET_SCAN: begin
                if (w_at_used) begin
                    w_bind = !w_full;
                end else if (w_match) begin
                    w_update = 1'b1;
                end else begin
                    w_idx_inc = 1'b1;
                end
            end
            ST_TICK_HIGH: begin
                if (w_out_free) begin
                    w_latch    = 1'b1;
                    w_level    = 1'b1;
                    w_keep     = w_hit_high && (r_nres != NRES_W'(MAX_RESULTS));
                    w_push_mid = w_keep && r_pend_valid;
                    w_idx_clr  = w_last_ch;
                    w_idx_inc  = !w_last_ch;
                end
            end
            ST_TICK_LOW: begin
                if (w_out_free) begin
                    w_keep     = w_hit_low && (r_nres != NRES_W'(MAX_RESULTS));
                    w_push_mid = w_keep && r_pend_valid;
                    w_idx_inc  = !w_last_ch;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    w_push_last  = r_pend_valid;
                    w_adv_period = 1'b1;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_used       <= '0;
            r_period     <= PERIOD_RESET;
            r_pend_valid <= 1'b0;
            r_nres       <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_chan_latched[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_idx_clr) begin
                r_idx <= '0;
            end else if (w_idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (w_bind) begin
                r_used <= r_used + UW'(1);
            end
            if (w_adv_period) begin
                r_period <= r_period + i_cfg.count_step;
            end
            if (w_latch) begin
                r_chan_latched[r_idx] <= w_masked;
            end
            if (w_tick_start) begin
                r_pend_valid <= 1'b0;
                r_nres       <= '0;
            end else if (w_keep) begin
                r_pend_valid <= 1'b1;
                r_nres       <= r_nres + NRES_W'(1);
            end else if (w_push_last) begin
                r_pend_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= w_push_mid || w_push_last;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_ld_cmd) begin
            r_cmd_pin  <= i_head.item.pin;
            r_cmd_duty <= i_head.item.duty;
        end
        if (w_bind) begin
            r_chan_pin[r_idx]  <= r_cmd_pin;
            r_chan_duty[r_idx] <= r_cmd_duty;
        end else if (w_update) begin
            r_chan_duty[r_idx] <= r_cmd_duty;
        end
        if (w_keep) begin
            r_pend_pin   <= w_cur_pin;
            r_pend_level <= w_level;
        end
        if (w_out_free) begin
            r_out.out_pin <= r_pend_pin;
            r_out.level   <= r_pend_level;
            r_out.last    <= w_push_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_busy      = (r_state != ST_IDLE);
    assign o_used      = r_used;

endmodule

`default_nettype wire

[rtl/multichannel_soft_pwm.sv]
// Top level of the multichannel soft PWM block: configuration registers and
// the connection of mspwm_front and mspwm_engine. Depends on mspwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Multichannel soft PWM generator. Input words either bind a pin to a PWM
// channel and set its duty (cmd set) or advance the 8-bit period counter by
// one step (cmd tick). Each tick produces zero to eight pin-write words on the
// output channel: at counter zero every channel in use latches its masked duty
// and writes its pin high when that is nonzero; then every channel whose
// latched duty equals the counter (and differs from the duty mask) writes its
// pin low. The last word of a tick carries last = 1; a tick with nothing to
// write produces no word. Input words go into a two-entry queue, so the
// sender sees stall only when both entries are taken. The engine behind the
// queue takes one word at a time and walks the channel table one channel per
// cycle, except that a tick pauses while the output is stalled: a set scans
// until it finds its pin, a free channel or the end of a full table; a tick
// walks the channels in use once, or twice when the counter is zero and the
// high pass runs too. The output register holds a finished word while the
// receiver stalls, and the tick scan pauses for as long as that register holds
// a word the receiver has not taken yet. Configuration writes are always taken
// (ready stays high); register 0 is the duty mask, register 1 the counter step,
// and writes to other indexes are dropped. They are meant to happen while the
// block is idle.

module multichannel_soft_pwm #(
    parameter int CHANNELS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  mspwm_pkg::t_in_item                i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output mspwm_pkg::t_out_item               o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mspwm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mspwm_pkg::DATA_W-1:0]  i_cfg_data
);
    import mspwm_pkg::*;

    localparam int UW = $clog2(CHANNELS + 1);

    t_cfg          r_cfg;
    t_head         w_head;
    logic          w_pop;
    logic          w_busy;
    logic [UW-1:0] w_used;

    // The register file never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_mask  <= MASK_RESET;
            r_cfg.count_step <= STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DUTY_MASK:  r_cfg.duty_mask  <= i_cfg_data;
                CFG_COUNT_STEP: r_cfg.count_step <= i_cfg_data;
                default: begin
                    // Indexes beyond the register list are ignored.
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Front end: the queue that decouples the sender from the channel scan.
    mspwm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_pop      (w_pop),
        .o_head     (w_head)
    );

    // Back end: channel table, period counter and output register.
    mspwm_engine #(
        .CHANNELS (CHANNELS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .o_busy      (w_busy),
        .o_used      (w_used)
    );

    // The number of channels in use never exceeds the table size.
    a_used_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= UW'(CHANNELS))
        else $error("channel use count beyond table size");

    // Channels are never released, so the use count never drops.
    a_used_monotonic : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> w_used >= $past(w_used))
        else $error("channel use count decreased");

    // A new output word only appears while the engine works on a tick.
    a_out_from_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_busy))
        else $error("output word while engine idle");

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for multichannel_soft_pwm: directed and random words,
// a built-in prediction of the pin writes, random idling on both channels.
// Depends on mspwm_pkg and the multichannel_soft_pwm RTL.
`timescale 1ns / 1ps

module tb;
    import mspwm_pkg::*;

    localparam int CHANNELS     = 8;
    localparam int DRAIN_CYCLES = 80;      // room for three words in flight, each a tick at counter zero
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off that backs the block up
    localparam int CYCLE_LIMIT  = 300000;

    // An index that maps to no register; the block must drop writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic                 o_cfg_ready;

    multichannel_soft_pwm #(.CHANNELS(CHANNELS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Words waiting to be offered, and the pin writes that accepted ticks still owe.
    t_in_item  words_to_send[$];
    t_out_item pin_writes_due[$];

    int err_count  = 0;
    int cycle_count = 0;
    int idle_pct   = 0;        // chance in percent that either side starts an idle burst
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    logic hold_arm  = 1'b0;
    logic hold_done = 1'b0;

    // Our own copy of the channel table, the period counter and the registers.
    logic              tbl_bound   [CHANNELS];
    logic [DATA_W-1:0] tbl_pin     [CHANNELS];
    logic [DATA_W-1:0] tbl_duty    [CHANNELS];
    logic [DATA_W-1:0] tbl_latched [CHANNELS];
    logic [3:0]        tbl_used;
    logic [DATA_W-1:0] pwm_count;
    logic [DATA_W-1:0] cfg_mask;
    logic [DATA_W-1:0] cfg_step;

    // Pins that the directed part binds; the table is full after it, so random
    // sets mostly aim here to change duties of live channels.
    logic [DATA_W-1:0] hot_pins [8] = '{8'h00, 8'hff, 8'h5a, 8'ha5, 8'h01, 8'h02, 8'h03, 8'h04};

    task automatic flag_error(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic void clear_pwm_table();
        for (int i = 0; i < CHANNELS; i++) begin
            tbl_bound[i]   = 1'b0;
            tbl_pin[i]     = '0;
            tbl_duty[i]    = '0;
            tbl_latched[i] = '0;
        end
        tbl_used  = '0;
        pwm_count = PERIOD_RESET;
        cfg_mask  = MASK_RESET;
        cfg_step  = STEP_RESET;
    endfunction

    // A set word updates the channel already holding the pin, or else binds the
    // first free channel. With every channel taken the word is dropped.
    function automatic void bind_or_update(input logic [DATA_W-1:0] pin,
                                           input logic [DATA_W-1:0] duty);
        int free_ch;
        free_ch = -1;
        for (int i = 0; i < CHANNELS; i++) begin
            if (tbl_bound[i] && tbl_pin[i] == pin) begin
                tbl_duty[i] = duty;
                return;
            end
            if (free_ch < 0 && !tbl_bound[i])
                free_ch = i;
        end
        if (free_ch >= 0) begin
            tbl_bound[free_ch] = 1'b1;
            tbl_pin[free_ch]   = pin;
            tbl_duty[free_ch]  = duty;
            tbl_used           = 4'(free_ch + 1);
        end
    endfunction

    // One period step: high writes at counter zero, then low writes, each in
    // channel order, and the last write of the tick marked.
    function automatic void advance_period();
        t_out_item burst[$];
        t_out_item w;
        if (pwm_count == 0) begin
            for (int i = 0; i < tbl_used; i++) begin
                if (!tbl_bound[i])
                    continue;
                tbl_latched[i] = tbl_duty[i] & cfg_mask;
                if (tbl_latched[i] != 0 && burst.size() < MAX_RESULTS) begin
                    w = '{out_pin: tbl_pin[i], level: 1'b1, last: 1'b0};
                    burst.push_back(w);
                end
            end
        end
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_bound[i] && tbl_latched[i] == pwm_count && tbl_latched[i] != cfg_mask
                    && burst.size() < MAX_RESULTS) begin
                w = '{out_pin: tbl_pin[i], level: 1'b0, last: 1'b0};
                burst.push_back(w);
            end
        end
        pwm_count = pwm_count + cfg_step;
        if (burst.size() > 0)
            burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i])
            pin_writes_due.push_back(burst[i]);
    endfunction

    function automatic void predict_word(input t_in_item w);
        if (w.cmd == CMD_SET)
            bind_or_update(w.pin, w.duty);
        else
            advance_period();
    endfunction

    function automatic void queue_word(input logic cmd, input logic [DATA_W-1:0] pin,
                                       input logic [DATA_W-1:0] duty);
        t_in_item w;
        w.cmd  = cmd;
        w.pin  = pin;
        w.duty = duty;
        words_to_send.push_back(w);
    endfunction

    // Mostly ticks, so that writes keep coming; sets mostly aim at bound pins, some
    // with duties that the counter will actually meet under the current step.
    function automatic void queue_random_word();
        logic [DATA_W-1:0] pin;
        logic [DATA_W-1:0] duty;
        pin  = 8'($urandom_range(0, 255));
        duty = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 60) begin
            queue_word(CMD_TICK, pin, duty);
        end else begin
            if ($urandom_range(0, 4) != 0)
                pin = hot_pins[$urandom_range(0, 7)];
            case ($urandom_range(0, 3))
                0: duty = 8'(cfg_step * $urandom_range(0, 255));
                1: duty = cfg_mask;
                2: duty = '0;
                default: ;
            endcase
            queue_word(CMD_SET, pin, duty);
        end
    endfunction

    // Sender: a new word is put up only once the current one has been taken.
    // Prediction runs at the edge where a word is accepted, in acceptance order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid)
                predict_word(i_in_data);
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (words_to_send.size() > 0) begin
                if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                    // This cycle is the first of the gap; gap_left counts the rest.
                    gap_left   <= $urandom_range(0, 6);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_data  <= words_to_send.pop_front();
                    i_in_valid <= 1'b1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    task automatic check_pin_write(input t_out_item got);
        t_out_item want;
        if (pin_writes_due.size() == 0) begin
            flag_error($sformatf("unexpected write pin %0d level %0b last %0b",
                                 got.out_pin, got.level, got.last));
            return;
        end
        want = pin_writes_due.pop_front();
        if (got.out_pin !== want.out_pin)
            flag_error($sformatf("out_pin %0d, expected %0d", got.out_pin, want.out_pin));
        if (got.level !== want.level)
            flag_error($sformatf("level %0b on pin %0d, expected %0b",
                                 got.level, want.out_pin, want.level));
        if (got.last !== want.last)
            flag_error($sformatf("last %0b on pin %0d, expected %0b",
                                 got.last, want.out_pin, want.last));
    endtask

    // Receiver: checks every accepted word and stalls in random bursts, and for
    // the whole of the long hold-off when one is running.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall)
                check_pin_write(o_out_data);
            if (stall_left > 0)
                stall_left <= stall_left - 1;
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                stall_left <= $urandom_range(1, 7);
            i_out_stall <= (hold_left != 0) || (stall_left > 0);
        end
    end

    // The long hold-off runs once, counted here, while the sender keeps going.
    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[multichannel_soft_pwm] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DUTY_MASK)
            cfg_mask = val;
        else if (idx == CFG_COUNT_STEP)
            cfg_step = val;
    endtask

    // Idle means every word sent and every write seen; words that cause no
    // write may still be inside the block, so a drain follows.
    task automatic wait_quiet();
        @(negedge i_clk);
        while (words_to_send.size() != 0 || i_in_valid || pin_writes_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The counter only returns to zero if it sits on a multiple of the lowest
    // set bit of the step, so one tick with a fitting step lines it up first.
    task automatic run_phase(input logic [DATA_W-1:0] mask, input logic [DATA_W-1:0] step,
                             input int words, input int pct, input logic with_hold);
        int lowbit;
        lowbit = int'(step) & -int'(step);
        wait_quiet();
        if (pwm_count % lowbit != 0) begin
            write_reg(CFG_COUNT_STEP, 8'(lowbit - pwm_count % lowbit));
            @(negedge i_clk);
            queue_word(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            wait_quiet();
        end
        write_reg(CFG_DUTY_MASK, mask);
        write_reg(CFG_COUNT_STEP, step);
        @(negedge i_clk);
        idle_pct = pct;
        if (with_hold)
            hold_arm = 1'b1;
        repeat (words) queue_random_word();
    endtask

    initial begin
        clear_pwm_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_DUTY_MASK, 8'hff);
        write_reg(CFG_COUNT_STEP, 8'd1);
        write_reg(CFG_UNUSED_IDX, 8'h5a);

        @(negedge i_clk);
        idle_pct = 20;
        // Fresh bindings, including the extreme pins and duties; zero duty never
        // goes high, and a duty equal to the mask never goes low.
        queue_word(CMD_SET, 8'h00, 8'd2);
        queue_word(CMD_SET, 8'hff, 8'hff);
        queue_word(CMD_SET, 8'h5a, 8'h00);
        queue_word(CMD_SET, 8'ha5, 8'd1);
        // Same pin again: only the duty of its channel changes.
        queue_word(CMD_SET, 8'h00, 8'd3);
        // Counter at 255 gives nothing; at zero, highs come before the low.
        queue_word(CMD_TICK, 8'hff, 8'hff);
        queue_word(CMD_TICK, 8'h00, 8'h00);
        queue_word(CMD_TICK, 8'h12, 8'h34);
        // A new duty on a running channel waits for the next period start.
        queue_word(CMD_SET, 8'ha5, 8'd2);
        queue_word(CMD_TICK, 8'h00, 8'h00);
        queue_word(CMD_TICK, 8'h00, 8'h00);
        queue_word(CMD_SET, 8'h01, 8'h80);
        queue_word(CMD_SET, 8'h02, 8'h7f);
        queue_word(CMD_SET, 8'h03, 8'h01);
        queue_word(CMD_SET, 8'h04, 8'hfe);
        // All eight channels taken, so this pin is not bound.
        queue_word(CMD_SET, 8'h33, 8'd9);
        queue_word(CMD_TICK, 8'h55, 8'haa);
        queue_word(CMD_TICK, 8'haa, 8'h55);

        run_phase(8'hff, 8'd16,  60, 25, 1'b1);
        run_phase(8'h0f, 8'd2,   30, 10, 1'b0);
        run_phase(8'h00, 8'd128, 15, 0,  1'b0);
        run_phase(8'hf0, 8'd32,  50, 40, 1'b0);
        run_phase(8'h3c, 8'd4,   40, 25, 1'b0);
        // Last stretch runs with neither side idling.
        run_phase(8'hff, 8'd8,   50, 0,  1'b0);

        wait_quiet();
        if (err_count == 0)
            $display("[multichannel_soft_pwm] OK");
        else
            $display("[multichannel_soft_pwm] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/mspwm_pkg.sv
rtl/mspwm_front.sv
rtl/mspwm_engine.sv
rtl/multichannel_soft_pwm.sv
sim/tb.sv
